[src/ognq_pkg.sv]
// Shared types and constants of the occupancy grid neighbor query block.
// No dependencies; ognq_mask and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package ognq_pkg;

  // Operation carried by each input beat. Codes 6 and 7 answer like a read.
  typedef enum logic [2:0] {
    MODE_BLOCK    = 3'd0,
    MODE_UNBLOCK  = 3'd1,
    MODE_SET_MARK = 3'd2,
    MODE_READ     = 3'd3,
    MODE_LOAD     = 3'd4,
    MODE_QUERY    = 3'd5
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_DIAG_ENABLE = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [6:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [6:0] GRID_HEIGHT_RST = 7'd64;

  localparam logic [7:0] BLANK_MARK = 8'h20;

  // Which neighbors of the addressed cell lie inside the grid in use.
  typedef struct packed {
    logic diag_en;
    logic left;
    logic right;
    logic up;
    logic down;
  } nbr_flags_t;

endpackage

[src/ognq_in_if.sv]
// Input channel of the occupancy grid block: valid/ready and one command beat.
// Field widths follow the constants of the block; no package dependency.
`timescale 1ns / 1ps

interface ognq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [6:0] col;
  logic [6:0] row;
  logic [7:0] mark_char;
  logic [7:0] cell_bits;

  modport source (output valid, mode, col, row, mark_char, cell_bits, input ready);
  modport sink   (input valid, mode, col, row, mark_char, cell_bits, output ready);
endinterface

[src/ognq_out_if.sv]
// Output channel of the occupancy grid block: valid/ready and one result beat.
// No package dependency.
`timescale 1ns / 1ps

interface ognq_out_if;
  logic       valid;
  logic       ready;
  logic       in_range;
  logic       cell_blocked;
  logic [7:0] cell_mark;
  logic [7:0] neighbor_mask;

  modport source (output valid, in_range, cell_blocked, cell_mark, neighbor_mask,
                  input ready);
  modport sink   (input valid, in_range, cell_blocked, cell_mark, neighbor_mask,
                  output ready);
endinterface

[src/ognq_mask.sv]
// Open-neighbor mask from the three blocked-bit rows around the addressed cell.
// Depends on ognq_pkg for the neighbor flag struct.
`timescale 1ns / 1ps

module ognq_mask #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  ognq_pkg::nbr_flags_t           flags_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]   col_i,
  input  logic [MAX_WIDTH-1:0]           up_row_i,
  input  logic [MAX_WIDTH-1:0]           mid_row_i,
  input  logic [MAX_WIDTH-1:0]           dn_row_i,
  output logic [7:0]                     mask_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  logic [CW-1:0] col_l;
  logic [CW-1:0] col_r;
  logic          diag;

  assign col_l = col_i - CW'(1);
  assign col_r = col_i + CW'(1);
  assign diag  = flags_i.diag_en;

  // Bit order: four diagonals, then below, above, left, right.
  assign mask_o[0] = diag & flags_i.right & flags_i.down & ~dn_row_i[col_r];
  assign mask_o[1] = diag & flags_i.right & flags_i.up   & ~up_row_i[col_r];
  assign mask_o[2] = diag & flags_i.left  & flags_i.up   & ~up_row_i[col_l];
  assign mask_o[3] = diag & flags_i.left  & flags_i.down & ~dn_row_i[col_l];
  assign mask_o[4] = flags_i.down  & ~dn_row_i[col_i];
  assign mask_o[5] = flags_i.up    & ~up_row_i[col_i];
  assign mask_o[6] = flags_i.left  & ~mid_row_i[col_l];
  assign mask_o[7] = flags_i.right & ~mid_row_i[col_r];

endmodule

[src/occupancy_grid_neighbor_query_top.sv]
// Top level of the occupancy grid neighbor query block.
// Depends on ognq_pkg, ognq_in_if, ognq_out_if and ognq_mask.
`timescale 1ns / 1ps

// The grid keeps a blocked bit and an 8-bit mark per cell in two synchronous
// memories: blocked bits as one word per row (MAX_WIDTH bits, MAX_HEIGHT rows)
// and marks as one byte per cell at address row*MAX_WIDTH+col. Each input beat
// is one command and yields exactly one result beat. For block, unblock, set
// mark, read and load, the accept cycle issues the reads; the next cycle
// returns the data and, once the output register is free, writes the
// modified row or mark back and loads the result register. An in-range
// neighbor query reads the addressed row, the row above and the row below
// one per cycle through the single read port of the row memory, then forms
// the mask. One item is in work at a time; a new beat is taken as soon as the
// sequencer is back at rest, even if the previous result still waits in the
// output register. After reset a clearing pass over all MAX_WIDTH*MAX_HEIGHT
// cells fills every mark with a space and clears every row; in_i.ready stays
// low meanwhile, while configuration writes are taken at any time. Grid width
// and height are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT when used.
module occupancy_grid_neighbor_query_top #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ognq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ognq_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ognq_in_if.sink                           in_i,
  ognq_out_if.source                        out_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(CELLS);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MID   = 5'b00100,
    ST_UP    = 5'b01000,
    ST_DN    = 5'b10000
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0] grid_width_q;
  logic [6:0] grid_height_q;
  logic       diag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= ognq_pkg::GRID_WIDTH_RST;
      grid_height_q <= ognq_pkg::GRID_HEIGHT_RST;
      diag_q        <= 1'b0;
    end else if (cfg_we_i) begin
      case (ognq_pkg::cfg_idx_e'(cfg_index_i))
        ognq_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i;
        ognq_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
        ognq_pkg::CFG_DIAG_ENABLE: diag_q        <= cfg_data_i[0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Clamp the size registers to the grid that the memories hold.
  logic [8:0] eff_w;
  logic [8:0] eff_h;

  always_comb begin
    if (grid_width_q == 7'd0) begin
      eff_w = 9'd1;
    end else if (9'(grid_width_q) > 9'(MAX_WIDTH)) begin
      eff_w = 9'(MAX_WIDTH);
    end else begin
      eff_w = 9'(grid_width_q);
    end
    if (grid_height_q == 7'd0) begin
      eff_h = 9'd1;
    end else if (9'(grid_height_q) > 9'(MAX_HEIGHT)) begin
      eff_h = 9'(MAX_HEIGHT);
    end else begin
      eff_h = 9'(grid_height_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and item registers
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [AW-1:0]     clr_q;
  ognq_pkg::mode_e   mode_q;
  logic [9:0]        x_q;
  logic [6:0]        y_q;
  logic [7:0]        mark_q;
  logic [7:0]        bits_q;
  logic              ok_q;
  logic [MAX_WIDTH-1:0] mid_row_q;
  logic [MAX_WIDTH-1:0] up_row_q;

  logic       in_fire;
  logic       out_free;
  logic [9:0] in_x;
  logic       in_ok;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_o.valid || out_o.ready;

  // Load addresses a byte column: the first cell sits at column 8*col.
  assign in_x  = (ognq_pkg::mode_e'(in_i.mode) == ognq_pkg::MODE_LOAD) ?
                 {in_i.col, 3'b000} : {3'b000, in_i.col};
  assign in_ok = (in_x < {1'b0, eff_w}) && (9'(in_i.row) < eff_h);

  // Neighbor rows and existence tests for the addressed cell.
  logic [8:0]           ry_up;
  logic [8:0]           ry_dn;
  logic [9:0]           x_next;
  ognq_pkg::nbr_flags_t flags;

  assign ry_up  = 9'(y_q) - 9'd1;
  assign ry_dn  = 9'(y_q) + 9'd1;
  assign x_next = x_q + 10'd1;

  assign flags.diag_en = diag_q;
  assign flags.left    = (x_q != 10'd0);
  assign flags.right   = (x_next < {1'b0, eff_w});
  assign flags.up      = (y_q != 7'd0);
  assign flags.down    = (ry_dn < eff_h);

  logic done;  // result register loads this cycle

  always_comb begin
    state_d = state_q;
    done    = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == AW'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        if (mode_q == ognq_pkg::MODE_QUERY && ok_q) begin
          state_d = ST_UP;
        end else if (out_free) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_UP: begin
        state_d = ST_DN;
      end
      ST_DN: begin
        if (out_free) begin
          done    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  // Capture the command beat; hold it for the whole item.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q <= ognq_pkg::mode_e'(in_i.mode);
      x_q    <= in_x;
      y_q    <= in_i.row;
      mark_q <= in_i.mark_char;
      bits_q <= in_i.cell_bits;
      ok_q   <= in_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Memories: blocked rows and cell marks
  // ---------------------------------------------------------------------------
  logic [MAX_WIDTH-1:0] blk_mem [MAX_HEIGHT];
  logic [7:0]           mark_mem [CELLS];

  logic                 row_re;
  logic [RW-1:0]        row_raddr;
  logic [MAX_WIDTH-1:0] row_rd_q;
  logic                 row_we;
  logic [RW-1:0]        row_waddr;
  logic [MAX_WIDTH-1:0] row_wdata;

  logic                 mark_re;
  logic [AW-1:0]        mark_raddr;
  logic [7:0]           mark_rd_q;
  logic                 mark_we;
  logic [AW-1:0]        mark_waddr;
  logic [7:0]           mark_wdata;

  logic [8:0]           in_row_ext;
  logic [AW-1:0]        item_addr;
  logic [CW-1:0]        xi;
  logic [MAX_WIDTH-1:0] new_row;
  logic [9:0]           load_col;

  assign in_row_ext = 9'(in_i.row);
  assign item_addr  = AW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
  assign xi         = x_q[CW-1:0];

  // Apply the command to the addressed row as it comes back from memory.
  always_comb begin
    new_row  = row_rd_q;
    load_col = x_q;
    case (mode_q)
      ognq_pkg::MODE_BLOCK:   new_row[xi] = 1'b1;
      ognq_pkg::MODE_UNBLOCK: new_row[xi] = 1'b0;
      ognq_pkg::MODE_LOAD: begin
        // Drop bits that fall at or past the grid width.
        for (int i = 0; i < 8; i++) begin
          load_col = x_q + 10'(i);
          if (load_col < {1'b0, eff_w}) begin
            new_row[load_col[CW-1:0]] = bits_q[i];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    row_re     = 1'b0;
    row_raddr  = in_row_ext[RW-1:0];
    mark_re    = 1'b0;
    mark_raddr = AW'(32'(in_i.row) * MAX_WIDTH + 32'(in_x));
    row_we     = 1'b0;
    row_waddr  = y_q[RW-1:0];
    row_wdata  = new_row;
    mark_we    = 1'b0;
    mark_waddr = item_addr;
    mark_wdata = mark_q;
    case (state_q)
      ST_CLEAR: begin
        row_we     = (32'(clr_q) < MAX_HEIGHT);
        row_waddr  = clr_q[RW-1:0];
        row_wdata  = '0;
        mark_we    = 1'b1;
        mark_waddr = clr_q;
        mark_wdata = ognq_pkg::BLANK_MARK;
      end
      ST_IDLE: begin
        row_re  = in_fire && in_ok;
        mark_re = in_fire && in_ok;
      end
      ST_MID: begin
        if (mode_q == ognq_pkg::MODE_QUERY) begin
          row_re    = ok_q && flags.up;
          row_raddr = ry_up[RW-1:0];
        end else if (done && ok_q) begin
          row_we  = (mode_q == ognq_pkg::MODE_BLOCK) ||
                    (mode_q == ognq_pkg::MODE_UNBLOCK) ||
                    (mode_q == ognq_pkg::MODE_LOAD);
          mark_we = (mode_q == ognq_pkg::MODE_SET_MARK);
        end
      end
      ST_UP: begin
        row_re    = flags.down;
        row_raddr = ry_dn[RW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      blk_mem[row_waddr] <= row_wdata;
    end
    if (row_re) begin
      row_rd_q <= blk_mem[row_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    if (mark_re) begin
      mark_rd_q <= mark_mem[mark_raddr];
    end
  end

  // Keep the addressed row and the row above while the row below is read.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MID) begin
      mid_row_q <= row_rd_q;
    end
    if (state_q == ST_UP) begin
      up_row_q <= row_rd_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Neighbor mask and result register
  // ---------------------------------------------------------------------------
  logic [7:0] nbr_mask;

  ognq_mask #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_mask (
    .flags_i   (flags),
    .col_i     (xi),
    .up_row_i  (up_row_q),
    .mid_row_i (mid_row_q),
    .dn_row_i  (row_rd_q),
    .mask_o    (nbr_mask)
  );

  logic       out_valid_q;
  logic       out_in_range_q;
  logic       out_blocked_q;
  logic [7:0] out_mark_q;
  logic [7:0] out_mask_q;
  logic       is_query;

  assign is_query = (state_q == ST_DN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Out-of-range cells answer all zeros.
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_in_range_q <= ok_q;
      if (!ok_q) begin
        out_blocked_q <= 1'b0;
        out_mark_q    <= 8'h00;
        out_mask_q    <= 8'h00;
      end else if (is_query) begin
        out_blocked_q <= mid_row_q[xi];
        out_mark_q    <= mark_rd_q;
        out_mask_q    <= nbr_mask;
      end else begin
        out_blocked_q <= new_row[xi];
        out_mark_q    <= (mode_q == ognq_pkg::MODE_SET_MARK) ? mark_q : mark_rd_q;
        out_mask_q    <= 8'h00;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.in_range      = out_in_range_q;
  assign out_o.cell_blocked  = out_blocked_q;
  assign out_o.cell_mark     = out_mark_q;
  assign out_o.neighbor_mask = out_mask_q;

endmodule
